@@ src/plsw_pkg.sv @@
package plsw_pkg;
  localparam int unsigned KindW = 3;
  localparam int unsigned SeqW = 16;
  localparam int unsigned TimerW = 24;
  localparam int unsigned CountW = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned CfgW = 16;
  localparam int unsigned LinkW = 4;

  typedef enum logic [2:0] {
    KIND_TICK = 3'd0, KIND_SEND = 3'd1, KIND_RECV = 3'd2,
    KIND_UACK_RX = 3'd3, KIND_UACK_TX = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0, ACT_TX = 3'd1, ACT_RETX = 3'd2, ACT_ACK = 3'd3,
    ACT_DELIVER = 3'd4, ACT_DUP = 3'd5, ACT_BUSY = 3'd6, ACT_FAIL = 3'd7
  } action_e;

  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgLimit = 1'b1;

  // Controller commands into the datapath.
  typedef struct packed {
    logic load;      // capture input item
    logic tick_step; // process link at scan index
    logic send;
    logic recv_a;    // first half of receive: reset, ack decision
    logic recv_b;    // second half: dup / deliver
    logic uack_rx;
    logic uack_tx;
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic emit;      // current step produced a result
    logic fail;      // current tick step failed
    logic more;      // a link after the scanned one will give a tick result
  } stat_t;

  function automatic logic serial_le(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return (d == '0) || d[SeqW-1];
  endfunction
endpackage

@@ src/plsw_dp.sv @@
module plsw_dp #(
  parameter int unsigned LINKS = 16,
  parameter int unsigned IdxW = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  plsw_pkg::cmd_t               cmd_i,
  input  logic [IdxW-1:0]              scan_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [plsw_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [plsw_pkg::LinkW-1:0]   link_i,
  input  logic [plsw_pkg::SeqW-1:0]    seq_i,
  input  logic                         want_ack_i,
  input  logic                         want_upper_ack_i,
  input  logic                         reliable_i,
  input  logic                         conn_reset_i,
  input  logic                         implicit_ok_i,
  input  logic                         has_cause_i,
  input  logic [plsw_pkg::SeqW-1:0]    cause_seq_i,
  output plsw_pkg::stat_t              stat_o,
  output logic [2:0]                   res_action_o,
  output logic [plsw_pkg::LinkW-1:0]   res_link_o,
  output logic [plsw_pkg::SeqW-1:0]    res_seq_o,
  output logic                         res_mark_o
);
  import plsw_pkg::*;

  logic [TimeoutW-1:0] timeout_q;
  logic [CountW-1:0]   limit_q;
  logic [LinkW-1:0] link_q;
  logic [SeqW-1:0]  seq_q, cause_q;
  logic wa_q, wu_q, rel_q, cr_q, imp_q, hc_q;

  logic [LINKS-1:0] waiting_q, ack_seen_q, uam_q, rpend_q;
  logic [SeqW-1:0]   awaited_q [LINKS];
  logic [CountW-1:0] count_q [LINKS];
  logic [TimerW-1:0] timer_q [LINKS];
  logic [SeqW-1:0]   high_q [LINKS];
  logic [SeqW-1:0]   useq_q [LINKS];

  logic [IdxW-1:0] li;
  logic [IdxW-1:0] si;
  logic in_range;
  assign li = IdxW'(link_q);
  assign si = scan_i;
  assign in_range = ({{(32-LinkW){1'b0}}, link_q} < LINKS);

  // Tick step combinational view of the scanned link.
  logic [TimerW-1:0] tdec;
  logic t_expire, t_fail, t_retx;
  logic [CountW-1:0] cnt_next;
  logic [TimerW+CountW-1:0] prod;
  always_comb begin
    tdec = (timer_q[si] != '0) ? timer_q[si] - 1'b1 : timer_q[si];
    t_expire = waiting_q[si] && !ack_seen_q[si] && (tdec == '0);
    t_fail = t_expire && (count_q[si] > limit_q);
    t_retx = t_expire && !t_fail;
    cnt_next = (count_q[si] != '1) ? count_q[si] + 1'b1 : count_q[si];
    prod = (TimerW+CountW)'(timeout_q) * (TimerW+CountW)'(cnt_next);
  end

  // Links after the scanned one whose timer runs out at this tick; earlier steps of
  // the same tick leave them alone unless the tick fails.
  logic later_due;
  always_comb begin
    later_due = 1'b0;
    for (int l = 0; l < LINKS; l++) begin
      if ((IdxW'(l) > si) && waiting_q[l] && !ack_seen_q[l] && (timer_q[l] <= TimerW'(1)))
        later_due = 1'b1;
    end
  end

  // Receive decisions.
  logic [SeqW-1:0] hcur;
  logic ack_need, is_dup;
  always_comb begin
    hcur = high_q[li];
    ack_need = (wa_q && !imp_q) || (wu_q && useq_q[li] == seq_q);
    is_dup = serial_le(seq_q, hcur) && (hcur != '0) && !imp_q && rel_q;
  end

  always_comb begin
    stat_o.emit = 1'b0;
    stat_o.fail = 1'b0;
    stat_o.more = 1'b0;
    if (cmd_i.tick_step) begin
      stat_o.emit = t_expire;
      stat_o.fail = t_fail;
      stat_o.more = later_due;
    end else if (cmd_i.send || cmd_i.recv_b || cmd_i.uack_tx) begin
      stat_o.emit = in_range;
    end else if (cmd_i.recv_a) begin
      stat_o.emit = in_range && ack_need;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      link_q <= link_i; seq_q <= seq_i; cause_q <= cause_seq_i;
      wa_q <= want_ack_i; wu_q <= want_upper_ack_i; rel_q <= reliable_i;
      cr_q <= conn_reset_i; imp_q <= implicit_ok_i; hc_q <= has_cause_i;
    end
    if (cmd_i.tick_step) begin
      res_link_o <= LinkW'(si);
      res_seq_o <= awaited_q[si];
      res_action_o <= t_fail ? ACT_FAIL : ACT_RETX;
      res_mark_o <= t_fail ? 1'b0 : rpend_q[si];
    end else if (cmd_i.send) begin
      res_link_o <= link_q; res_seq_o <= seq_q;
      res_action_o <= waiting_q[li] ? ACT_BUSY : ACT_TX;
      res_mark_o <= waiting_q[li] ? 1'b0 : rpend_q[li];
    end else if (cmd_i.recv_a || cmd_i.uack_tx) begin
      res_link_o <= link_q; res_seq_o <= seq_q;
      res_action_o <= ACT_ACK; res_mark_o <= 1'b0;
    end else if (cmd_i.recv_b) begin
      res_link_o <= link_q; res_seq_o <= seq_q;
      res_action_o <= is_dup ? ACT_DUP : ACT_DELIVER; res_mark_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutW'(50);
      limit_q <= CountW'(4);
      waiting_q <= '0; ack_seen_q <= '0; uam_q <= '0; rpend_q <= '1;
      for (int i = 0; i < LINKS; i++) begin
        awaited_q[i] <= '0; count_q[i] <= '0; timer_q[i] <= '0;
        high_q[i] <= '0; useq_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgTimeout) timeout_q <= cfg_data_i[TimeoutW-1:0];
        else limit_q <= cfg_data_i[CountW-1:0];
      end
      if (cmd_i.tick_step && waiting_q[si]) begin
        if (t_fail) begin
          waiting_q <= '0; ack_seen_q <= '0; uam_q <= '0; rpend_q <= '1;
          for (int i = 0; i < LINKS; i++) begin
            awaited_q[i] <= '0; count_q[i] <= '0; timer_q[i] <= '0;
            high_q[i] <= '0; useq_q[i] <= '0;
          end
        end else if (ack_seen_q[si]) begin
          waiting_q[si] <= 1'b0; ack_seen_q[si] <= 1'b0; rpend_q[si] <= 1'b0;
        end else begin
          timer_q[si] <= t_retx ? prod[TimerW-1:0] : tdec;
          if (t_retx) count_q[si] <= cnt_next;
        end
      end
      if (in_range) begin
        if (cmd_i.send && !waiting_q[li]) begin
          waiting_q[li] <= 1'b1; awaited_q[li] <= seq_q; count_q[li] <= '0;
          timer_q[li] <= TimerW'(timeout_q); ack_seen_q[li] <= 1'b0;
          uam_q[li] <= wu_q;
        end
        if (cmd_i.recv_a && cr_q) high_q[li] <= '0;
        if (cmd_i.recv_b && !is_dup) begin
          if (rel_q && (hcur == '0 || serial_le(hcur, seq_q))) high_q[li] <= seq_q;
          if (waiting_q[li] && !uam_q[li] && hc_q && cause_q == awaited_q[li])
            ack_seen_q[li] <= 1'b1;
        end
        if (cmd_i.uack_rx && waiting_q[li] && seq_q == awaited_q[li])
          ack_seen_q[li] <= 1'b1;
        if (cmd_i.uack_tx) useq_q[li] <= seq_q;
      end
    end
  end
endmodule

@@ src/plsw_ctrl.sv @@
module plsw_ctrl #(
  parameter int unsigned LINKS = 16,
  parameter int unsigned IdxW = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [plsw_pkg::KindW-1:0]   kind_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         last_o,
  input  plsw_pkg::stat_t              stat_i,
  output plsw_pkg::cmd_t               cmd_o,
  output logic [IdxW-1:0]              scan_o
);
  import plsw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_OUT, S_RECV_B, S_NEXT
  } state_e;

  state_e state_q;
  logic [KindW-1:0] kind_q;
  logic [IdxW-1:0] scan_q;
  logic out_v_q, last_q;
  logic cont_q; // more steps follow the shown result

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign last_o = last_q;
  assign scan_o = scan_q;

  logic scan_end;
  assign scan_end = ({{(32-IdxW){1'b0}}, scan_q} == LINKS - 1);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    if (state_q == S_EXEC) begin
      unique case (kind_q)
        KIND_TICK:    cmd_o.tick_step = 1'b1;
        KIND_SEND:    cmd_o.send = 1'b1;
        KIND_RECV:    cmd_o.recv_a = 1'b1;
        KIND_UACK_RX: cmd_o.uack_rx = 1'b1;
        KIND_UACK_TX: cmd_o.uack_tx = 1'b1;
        default: ;
      endcase
    end else if (state_q == S_RECV_B) begin
      cmd_o.recv_b = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; kind_q <= '0; scan_q <= '0;
      out_v_q <= 1'b0; last_q <= 1'b0; cont_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= kind_i; scan_q <= '0; state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (kind_q == KIND_TICK) begin
            if (stat_i.emit) begin
              out_v_q <= 1'b1;
              // Silent links after this one are still scanned, but show nothing.
              last_q <= stat_i.fail || scan_end || !stat_i.more;
              cont_q <= !(stat_i.fail || scan_end);
              state_q <= S_OUT;
            end else if (scan_end) begin
              state_q <= S_IDLE;
            end else begin
              scan_q <= scan_q + 1'b1;
            end
          end else if (kind_q == KIND_RECV) begin
            if (stat_i.emit) begin
              out_v_q <= 1'b1; last_q <= 1'b0; cont_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RECV_B;
            end
          end else if (stat_i.emit) begin
            out_v_q <= 1'b1; last_q <= 1'b1; cont_q <= 1'b0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RECV_B: begin
          if (stat_i.emit) begin
            out_v_q <= 1'b1; last_q <= 1'b1; cont_q <= 1'b0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_v_q <= 1'b0;
            state_q <= cont_q ? S_NEXT : S_IDLE;
          end
        end
        S_NEXT: begin
          if (kind_q == KIND_TICK) begin
            scan_q <= scan_q + 1'b1;
            state_q <= S_EXEC;
          end else begin
            state_q <= S_RECV_B;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/per_link_stop_and_wait_arq.sv @@
// Results: a link event that gives a result registers its first one from S_EXEC, or from
// S_RECV_B for a receive that sends no ack; a tick scans one link per cycle while no result is shown.
// One transaction is taken at a time.
// Output stalls add to each result. The last result of a tick is always marked last.
// Reset: all links ready with reset mark pending, timeout 50, limit 4.
module per_link_stop_and_wait_arq #(
  parameter int unsigned LINKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [plsw_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   kind_i,
  input  logic [3:0]                   link_i,
  input  logic [15:0]                  seq_i,
  input  logic                         want_ack_i,
  input  logic                         want_upper_ack_i,
  input  logic                         reliable_i,
  input  logic                         conn_reset_i,
  input  logic                         implicit_ok_i,
  input  logic                         has_cause_i,
  input  logic [15:0]                  cause_seq_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   action_o,
  output logic [3:0]                   out_link_o,
  output logic [15:0]                  out_seq_o,
  output logic                         reset_mark_o,
  output logic                         last_o
);
  import plsw_pkg::*;
  localparam int unsigned IdxW = (LINKS > 1) ? $clog2(LINKS) : 1;

  cmd_t cmd;
  stat_t stat;
  logic [IdxW-1:0] scan;

  plsw_ctrl #(.LINKS(LINKS), .IdxW(IdxW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .out_ready_i,
    .out_valid_o, .last_o, .stat_i(stat), .cmd_o(cmd), .scan_o(scan)
  );

  plsw_dp #(.LINKS(LINKS), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .scan_i(scan), .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]),
    .cfg_data_i, .link_i, .seq_i, .want_ack_i, .want_upper_ack_i, .reliable_i,
    .conn_reset_i, .implicit_ok_i, .has_cause_i, .cause_seq_i, .stat_o(stat),
    .res_action_o(action_o), .res_link_o(out_link_o), .res_seq_o(out_seq_o),
    .res_mark_o(reset_mark_o)
  );
endmodule

@@ tb/sv/per_link_stop_and_wait_arq_test.sv @@
`timescale 1ns / 100ps

module per_link_stop_and_wait_arq_test;
  import plsw_pkg::*;

  localparam int NLinks = 16;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int SettleCycles = 2 * NLinks + 8;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  link;
    logic [15:0] seq;
    logic        want_ack;
    logic        want_ul;
    logic        reliable;
    logic        conn_reset;
    logic        implicit_ok;
    logic        has_cause;
    logic [15:0] cause;
  } event_t;

  typedef struct {
    action_e     action;
    logic [3:0]  link;
    logic [15:0] seq;
    logic        mark;
    logic        last;
  } verdict_t;

  typedef struct {
    event_t   ev;
    bit       typed;
    verdict_t want;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] kind;
  logic [3:0] link;
  logic [15:0] seq, cause_seq;
  logic want_ack, want_ul, reliable, conn_reset, implicit_ok, has_cause;
  logic out_valid, out_ready;
  logic [2:0] action;
  logic [3:0] out_link;
  logic [15:0] out_seq;
  logic reset_mark, last;

  per_link_stop_and_wait_arq dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .link_i(link), .seq_i(seq),
    .want_ack_i(want_ack), .want_upper_ack_i(want_ul), .reliable_i(reliable),
    .conn_reset_i(conn_reset), .implicit_ok_i(implicit_ok),
    .has_cause_i(has_cause), .cause_seq_i(cause_seq),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .action_o(action), .out_link_o(out_link), .out_seq_o(out_seq),
    .reset_mark_o(reset_mark), .last_o(last)
  );

  // Shadow copy of the link table and registers.
  logic [15:0] cfg_tmo;
  logic [7:0]  cfg_lim;
  logic        lk_wait[NLinks];
  logic [15:0] lk_awaited[NLinks];
  logic [7:0]  lk_retries[NLinks];
  logic [23:0] lk_timer[NLinks];
  logic        lk_acked[NLinks];
  logic        lk_ul_mode[NLinks];
  logic        lk_rst_pend[NLinks];
  logic [15:0] lk_highest[NLinks];
  logic [15:0] lk_ul_seq[NLinks];

  verdict_t pending_q[$];
  verdict_t step_q[$];
  int  errors = 0;
  bit  idle_on = 0;
  int  rx_hold = 0;

  function automatic bit seq_not_after(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d == 16'd0) || d[15];
  endfunction

  function automatic void links_clear();
    for (int l = 0; l < NLinks; l++) begin
      lk_wait[l] = 0; lk_awaited[l] = 0; lk_retries[l] = 0; lk_timer[l] = 0;
      lk_acked[l] = 0; lk_ul_mode[l] = 0; lk_rst_pend[l] = 1;
      lk_highest[l] = 0; lk_ul_seq[l] = 0;
    end
  endfunction

  function automatic void add_verdict(action_e a, int l, logic [15:0] s, logic m);
    verdict_t v;
    v.action = a; v.link = l[3:0]; v.seq = s; v.mark = m; v.last = 0;
    step_q.push_back(v);
  endfunction

  function automatic void scan_links();
    logic [31:0] prod;
    for (int l = 0; l < NLinks; l++) begin
      if (!lk_wait[l]) continue;
      if (lk_acked[l]) begin
        lk_wait[l] = 0; lk_acked[l] = 0; lk_rst_pend[l] = 0;
        continue;
      end
      if (lk_timer[l] != 0) lk_timer[l]--;
      if (lk_timer[l] != 0) continue;
      if (lk_retries[l] <= cfg_lim) begin
        if (lk_retries[l] != 8'd255) lk_retries[l]++;
        prod = cfg_tmo * lk_retries[l];
        lk_timer[l] = prod[23:0];
        add_verdict(ACT_RETX, l, lk_awaited[l], lk_rst_pend[l]);
      end else begin
        add_verdict(ACT_FAIL, l, lk_awaited[l], 1'b0);
        links_clear();
        return;
      end
    end
  endfunction

  // Fills step_q with what one transaction produces.
  function automatic void arq_predict(event_t e);
    int l;
    logic [15:0] h;
    l = e.link;
    step_q.delete();
    case (e.kind)
      KIND_TICK: scan_links();
      KIND_SEND: begin
        if (lk_wait[l]) add_verdict(ACT_BUSY, l, e.seq, 1'b0);
        else begin
          lk_wait[l] = 1; lk_awaited[l] = e.seq; lk_retries[l] = 0;
          lk_timer[l] = {8'd0, cfg_tmo}; lk_acked[l] = 0; lk_ul_mode[l] = e.want_ul;
          add_verdict(ACT_TX, l, e.seq, lk_rst_pend[l]);
        end
      end
      KIND_RECV: begin
        if (e.conn_reset) lk_highest[l] = 0;
        if ((e.want_ack && !e.implicit_ok) || (e.want_ul && lk_ul_seq[l] == e.seq))
          add_verdict(ACT_ACK, l, e.seq, 1'b0);
        h = lk_highest[l];
        if (seq_not_after(e.seq, h) && h != 0 && !e.implicit_ok && e.reliable) begin
          add_verdict(ACT_DUP, l, e.seq, 1'b0);
        end else begin
          if (e.reliable && (h == 0 || seq_not_after(h, e.seq))) lk_highest[l] = e.seq;
          if (lk_wait[l] && !lk_ul_mode[l] && e.has_cause && e.cause == lk_awaited[l])
            lk_acked[l] = 1;
          add_verdict(ACT_DELIVER, l, e.seq, 1'b0);
        end
      end
      KIND_UACK_RX: if (lk_wait[l] && e.seq == lk_awaited[l]) lk_acked[l] = 1;
      KIND_UACK_TX: begin
        lk_ul_seq[l] = e.seq;
        add_verdict(ACT_ACK, l, e.seq, 1'b0);
      end
      default: ;
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
  endfunction

  function automatic event_t mk_event(logic [2:0] k, int l, int s, bit wa, bit wu,
                                      bit rel, bit cr, bit imp, bit hc, int c);
    event_t e;
    e.kind = k; e.link = l[3:0]; e.seq = s[15:0]; e.want_ack = wa; e.want_ul = wu;
    e.reliable = rel; e.conn_reset = cr; e.implicit_ok = imp; e.has_cause = hc;
    e.cause = c[15:0];
    return e;
  endfunction

  function automatic event_t random_event();
    event_t e;
    int r, l;
    r = $urandom_range(0, 99);
    l = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    e = mk_event(KIND_TICK, l, $urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), ($urandom_range(0, 7) == 0),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
    if (r < 30) e.kind = KIND_TICK;
    else if (r < 55) begin
      e.kind = KIND_SEND;
      e.want_ul = ($urandom_range(0, 2) == 0);
    end else if (r < 85) begin
      e.kind = KIND_RECV;
      case ($urandom_range(0, 3))
        0: e.seq = lk_highest[l] + 16'($urandom_range(0, 5)) - 16'd2;
        1: e.seq = lk_ul_seq[l];
        default: ;
      endcase
      if ($urandom_range(0, 4) < 3) e.cause = lk_awaited[l];
    end else if (r < 93) begin
      e.kind = KIND_UACK_RX;
      if ($urandom_range(0, 9) < 7) e.seq = lk_awaited[l];
    end else if (r < 98) e.kind = KIND_UACK_TX;
    else e.kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
    return e;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: checks every result against the oldest expectation.
  initial begin
    int rx_wait;
    verdict_t w;
    rx_wait = 0;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ready && out_valid) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result action=%0d link=%0d seq=%h", $time,
                   action, out_link, out_seq);
        end else begin
          w = pending_q.pop_front();
          if (action !== w.action || out_link !== w.link || out_seq !== w.seq ||
              reset_mark !== w.mark || last !== w.last) begin
            errors++;
            $display("%0t: mismatch expected act=%0d link=%0d seq=%h mark=%0b last=%0b",
                     $time, w.action, w.link, w.seq, w.mark, w.last);
            $display("%0t:          actual   act=%0d link=%0d seq=%h mark=%0b last=%0b",
                     $time, action, out_link, out_seq, reset_mark, last);
          end
        end
        rx_wait = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (rx_hold > 0) begin
        out_ready <= 0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_ready <= 0;
        rx_wait--;
      end else out_ready <= 1;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CfgTimeout) cfg_tmo = val;
    else cfg_lim = val[7:0];
  endtask

  task automatic offer(event_t e, bit typed, verdict_t want);
    int gap;
    @(posedge clk);
    in_valid <= 1;
    kind <= e.kind; link <= e.link; seq <= e.seq; want_ack <= e.want_ack;
    want_ul <= e.want_ul; reliable <= e.reliable; conn_reset <= e.conn_reset;
    implicit_ok <= e.implicit_ok; has_cause <= e.has_cause; cause_seq <= e.cause;
    do @(posedge clk); while (!in_ready);
    arq_predict(e);
    if (typed) pending_q.push_back(want);
    else foreach (step_q[i]) pending_q.push_back(step_q[i]);
    gap = idle_on ? $urandom_range(0, 13) : 0;
    // The accepted transaction is withdrawn before the next one is offered.
    in_valid <= 0;
    if (gap > 0) repeat (gap - 1) @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    row_t dir_tab[$];
    row_t r;
    verdict_t none;
    int tmo_set[6], lim_set[6];
    none = '{ACT_NONE, 4'd0, 16'd0, 1'b0, 1'b0};
    rst_n = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0; in_valid = 0;
    kind = 0; link = 0; seq = 0; cause_seq = 0; want_ack = 0; want_ul = 0;
    reliable = 0; conn_reset = 0; implicit_ok = 0; has_cause = 0;
    cfg_tmo = 16'd50; cfg_lim = 8'd4;
    links_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1;

    r.typed = 1;
    r.ev = mk_event(KIND_SEND, 0, 'h1234, 0, 0, 0, 0, 0, 0, 0);
    r.want = '{ACT_TX, 4'd0, 16'h1234, 1'b1, 1'b1}; dir_tab.push_back(r);
    r.ev = mk_event(KIND_SEND, 0, 'h0005, 0, 0, 0, 0, 0, 0, 0);
    r.want = '{ACT_BUSY, 4'd0, 16'h0005, 1'b0, 1'b1}; dir_tab.push_back(r);
    r.ev = mk_event(KIND_SEND, 15, 'hFFFF, 1, 1, 1, 1, 1, 1, 'hFFFF);
    r.want = '{ACT_TX, 4'd15, 16'hFFFF, 1'b1, 1'b1}; dir_tab.push_back(r);
    r.ev = mk_event(KIND_UACK_TX, 3, 'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    r.want = '{ACT_ACK, 4'd3, 16'hFFFF, 1'b0, 1'b1}; dir_tab.push_back(r);
    r.typed = 0; r.want = none;
    r.ev = mk_event(KIND_RECV, 3, 'hFFFF, 0, 1, 1, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 3, 'hFFFF, 1, 0, 1, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 3, 'hFFF0, 0, 0, 1, 0, 1, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 15, 'h0007, 0, 0, 1, 0, 0, 1, 'hFFFF); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 0, 'h0001, 1, 0, 1, 0, 0, 1, 'h1234); dir_tab.push_back(r);
    r.ev = mk_event(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_UACK_RX, 15, 'hFFFF, 0, 0, 0, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 3, 'h0001, 0, 0, 1, 1, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RECV, 3, 'h0001, 1, 0, 1, 0, 1, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RSVD_LO, 2, 'h5555, 1, 1, 1, 1, 1, 1, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_RSVD_HI, 9, 'hAAAA, 1, 1, 1, 1, 1, 1, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_SEND, 0, 'h8000, 0, 0, 0, 0, 0, 0, 0); dir_tab.push_back(r);
    r.ev = mk_event(KIND_SEND, 15, 'h0000, 0, 0, 0, 0, 0, 0, 0); dir_tab.push_back(r);
    foreach (dir_tab[i]) offer(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // Register settings per phase; zero timeout and the limit extremes included.
    tmo_set = '{0, 1, 65535, 2, 7, $urandom_range(1, 20)};
    lim_set = '{0, 2, 255, 254, 1, $urandom_range(0, 5)};
    for (int p = 0; p < 6; p++) begin
      write_reg(CfgTimeout, tmo_set[p][15:0]);
      write_reg(CfgLimit, lim_set[p][15:0]);
      idle_on = (p % 2 == 1);
      // Hold the result side off long enough for the block to back up.
      if (p == 2) rx_hold = 400;
      for (int i = 0; i < 40; i++) offer(random_event(), 0, none);
      drain();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
